[sv/sma_pkg.sv]
package sma_pkg;

	localparam int NUM_CLASSES = 7;
	localparam int SCORE_W = 8;
	localparam int GAP_W = 8;
	localparam int EXP_W = 17;
	localparam int SUM_W = 19;
	localparam int NUM_W = 34;
	localparam int QUO_W = 17;
	localparam int TOP_W = 3;
	localparam int CONF_W = 15;
	localparam int PROD_W = 32;
	localparam int LANES = NUM_CLASSES + 1;
	localparam int CONF_LANE = NUM_CLASSES;
	localparam int PROB_SHIFT = 16;
	localparam logic [CONF_W-1:0] CONF_FULL = 15'd25600;
	localparam logic [TOP_W-1:0] TOP_MAX = 3'(NUM_CLASSES - 1);

	typedef logic [EXP_W-1:0] exp_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [QUO_W-1:0] quo_t;
	typedef logic [TOP_W-1:0] top_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score_0;
		logic signed [SCORE_W-1:0] score_1;
		logic signed [SCORE_W-1:0] score_2;
		logic signed [SCORE_W-1:0] score_3;
		logic signed [SCORE_W-1:0] score_4;
		logic signed [SCORE_W-1:0] score_5;
		logic signed [SCORE_W-1:0] score_6;
	} scores_t;

	typedef struct packed {
		logic [QUO_W-1:0] prob_0;
		logic [QUO_W-1:0] prob_1;
		logic [QUO_W-1:0] prob_2;
		logic [QUO_W-1:0] prob_3;
		logic [QUO_W-1:0] prob_4;
		logic [QUO_W-1:0] prob_5;
		logic [QUO_W-1:0] prob_6;
		logic [TOP_W-1:0] top_class;
		logic [CONF_W-1:0] confidence_pct;
	} result_t;

	// e^-gap in q16, rounded from a q24 table
	function automatic exp_t exp_lut(input logic [GAP_W-1:0] gap);
		exp_t v;
		case (gap)
			8'd0:  v = 17'd65536;
			8'd1:  v = 17'd24109;
			8'd2:  v = 17'd8869;
			8'd3:  v = 17'd3263;
			8'd4:  v = 17'd1200;
			8'd5:  v = 17'd442;
			8'd6:  v = 17'd162;
			8'd7:  v = 17'd60;
			8'd8:  v = 17'd22;
			8'd9:  v = 17'd8;
			8'd10: v = 17'd3;
			8'd11: v = 17'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[sv/sma_div.sv]
module sma_div (
	input  logic           clk,
	input  sma_pkg::num_t  num,
	input  sma_pkg::sum_t  den,
	output sma_pkg::quo_t  quo
);

	localparam int CW = sma_pkg::NUM_W + 2;

	sma_pkg::num_t rem_st [0:sma_pkg::QUO_W];
	sma_pkg::sum_t den_st [0:sma_pkg::QUO_W];
	sma_pkg::quo_t quo_st [0:sma_pkg::QUO_W];

	assign rem_st[0] = num;
	assign den_st[0] = den;
	assign quo_st[0] = '0;

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < sma_pkg::QUO_W; k++) begin : g_stage
		localparam int B = sma_pkg::QUO_W - 1 - k;
		logic [CW-1:0] dsh;
		logic [CW-1:0] rx;
		logic          ge;
		assign dsh = CW'(den_st[k]) << B;
		assign rx = CW'(rem_st[k]);
		assign ge = rx >= dsh;
		always_ff @(posedge clk) begin
			rem_st[k+1] <= ge ? sma_pkg::NUM_W'(rx - dsh) : rem_st[k];
			den_st[k+1] <= den_st[k];
			quo_st[k+1] <= {quo_st[k][sma_pkg::QUO_W-2:0], ge};
		end
	end

	assign quo = quo_st[sma_pkg::QUO_W];

endmodule

[sv/sma_front.sv]
module sma_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld,
	input  sma_pkg::scores_t scores,
	output logic             vld_out,
	output sma_pkg::num_t    num [0:sma_pkg::LANES-1],
	output sma_pkg::sum_t    den,
	output sma_pkg::top_t    top
);

	logic signed [sma_pkg::SCORE_W-1:0] sc [0:sma_pkg::NUM_CLASSES-1];
	logic signed [sma_pkg::SCORE_W-1:0] sc_s1 [0:sma_pkg::NUM_CLASSES-1];
	logic signed [sma_pkg::SCORE_W-1:0] mx;
	logic signed [sma_pkg::SCORE_W-1:0] mx_s1;
	sma_pkg::top_t top_c, top_s1, top_s2, top_s3, top_s4;
	sma_pkg::exp_t e_s2 [0:sma_pkg::NUM_CLASSES-1];
	sma_pkg::exp_t e_s3 [0:sma_pkg::NUM_CLASSES-1];
	sma_pkg::sum_t sum_c, sum_s3, den_s4;
	logic [sma_pkg::PROD_W-1:0] conf_s3;
	sma_pkg::num_t num_s4 [0:sma_pkg::LANES-1];
	logic v_s1, v_s2, v_s3, v_s4;

	assign sc[0] = scores.score_0;
	assign sc[1] = scores.score_1;
	assign sc[2] = scores.score_2;
	assign sc[3] = scores.score_3;
	assign sc[4] = scores.score_4;
	assign sc[5] = scores.score_5;
	assign sc[6] = scores.score_6;

	// first maximum wins
	always_comb begin
		mx = sc[0];
		top_c = '0;
		for (int i = 1; i < sma_pkg::NUM_CLASSES; i++) begin
			if (sc[i] > mx) begin
				mx = sc[i];
				top_c = sma_pkg::TOP_W'(i);
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < sma_pkg::NUM_CLASSES; i++) begin
			sum_c = sum_c + sma_pkg::SUM_W'(e_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sc_s1 <= sc;
		mx_s1 <= mx;
		top_s1 <= top_c;
		for (int i = 0; i < sma_pkg::NUM_CLASSES; i++) begin
			e_s2[i] <= sma_pkg::exp_lut(sma_pkg::GAP_W'(
				9'(mx_s1) - 9'(sc_s1[i])));
		end
		top_s2 <= top_s1;
		e_s3 <= e_s2;
		sum_s3 <= sum_c;
		conf_s3 <= sma_pkg::PROD_W'(e_s2[top_s2]) * sma_pkg::PROD_W'(sma_pkg::CONF_FULL);
		top_s3 <= top_s2;
		for (int i = 0; i < sma_pkg::NUM_CLASSES; i++) begin
			num_s4[i] <= (sma_pkg::NUM_W'(e_s3[i]) << sma_pkg::PROB_SHIFT)
				+ sma_pkg::NUM_W'(sum_s3 >> 1);
		end
		num_s4[sma_pkg::CONF_LANE] <= sma_pkg::NUM_W'(conf_s3)
			+ sma_pkg::NUM_W'(sum_s3 >> 1);
		den_s4 <= sum_s3;
		top_s4 <= top_s3;
	end

	assign vld_out = v_s4;
	assign num = num_s4;
	assign den = den_s4;
	assign top = top_s4;

endmodule

[sv/int8_softmax_argmax.sv]
// softmax and argmax over seven signed 8-bit class scores
//
// a beat is taken at each rising edge where start is high and busy is low;
// busy is always low, so a new score vector may be offered every cycle
// each accepted beat yields exactly one result beat,
// marked by a one-cycle done strobe on the result struct
// result carries seven q1.16 probabilities, the index of the first
// maximal class and its confidence in percent, q8
// pipeline: 4 front stages (max, exp table, sum, rounding numerators)
// then a 17-stage divider, one quotient bit per stage, in eight lanes
// throughput: one beat per cycle, sustained
// the receiver cannot stall: done is shown for one cycle only
// reset clears all valid flags; beats in flight are dropped
module int8_softmax_argmax (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sma_pkg::scores_t  scores,
	output logic              done,
	output sma_pkg::result_t  result
);

	sma_pkg::num_t num [0:sma_pkg::LANES-1];
	sma_pkg::quo_t quo [0:sma_pkg::LANES-1];
	sma_pkg::sum_t den;
	sma_pkg::top_t top_f;
	sma_pkg::top_t top_q [0:sma_pkg::QUO_W-1];
	logic [sma_pkg::QUO_W-1:0] v_q;
	logic v_f;

	assign busy = 1'b0;

	sma_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start),
		.scores  (scores),
		.vld_out (v_f),
		.num     (num),
		.den     (den),
		.top     (top_f)
	);

	for (genvar l = 0; l < sma_pkg::LANES; l++) begin : g_lane
		sma_div u_div (
			.clk (clk),
			.num (num[l]),
			.den (den),
			.quo (quo[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[sma_pkg::QUO_W-2:0], v_f};
		end
	end

	always_ff @(posedge clk) begin
		top_q[0] <= top_f;
		for (int i = 1; i < sma_pkg::QUO_W; i++) begin
			top_q[i] <= top_q[i-1];
		end
	end

	assign done = v_q[sma_pkg::QUO_W-1];
	assign result.prob_0 = quo[0];
	assign result.prob_1 = quo[1];
	assign result.prob_2 = quo[2];
	assign result.prob_3 = quo[3];
	assign result.prob_4 = quo[4];
	assign result.prob_5 = quo[5];
	assign result.prob_6 = quo[6];
	assign result.top_class = top_q[sma_pkg::QUO_W-1];
	assign result.confidence_pct = sma_pkg::CONF_W'(quo[sma_pkg::CONF_LANE]);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##21 done)
		else $error("result beat missing");
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.top_class <= sma_pkg::TOP_MAX)
		else $error("top class out of range");
	a_conf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> quo[sma_pkg::CONF_LANE] <= sma_pkg::QUO_W'(sma_pkg::CONF_FULL))
		else $error("confidence above full scale");

endmodule

[verif/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sma_pkg::scores_t scores;
	logic done;
	sma_pkg::result_t result;

	sma_pkg::scores_t pending_vectors[$];
	sma_pkg::result_t expected_results[$];
	int errors;
	bit stim_done;

	int8_softmax_argmax dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.scores(scores),
		.done(done),
		.result(result)
	);

	// e^-gap in q16 from the q24 table, rounded ties up
	function automatic longint unsigned exp_q16(int gap);
		longint unsigned rom[18] = '{16777216, 6171993, 2270549, 835288, 307285, 113044,
			41587, 15299, 5628, 2070, 762, 280, 103, 38, 14, 5, 2, 1};
		if (gap >= 18)
			return 0;
		return (rom[gap] + 128) >> 8;
	endfunction

	function automatic sma_pkg::result_t softmax_of(sma_pkg::scores_t v);
		int s[7];
		longint unsigned e[7];
		longint unsigned sum;
		longint unsigned p[7];
		int mx;
		int top;
		sma_pkg::result_t r;
		s = '{int'(v.score_0), int'(v.score_1), int'(v.score_2), int'(v.score_3),
			int'(v.score_4), int'(v.score_5), int'(v.score_6)};
		mx = s[0];
		top = 0;
		for (int i = 1; i < 7; i++)
			if (s[i] > mx) begin
				mx = s[i];
				top = i;
			end
		sum = 0;
		for (int i = 0; i < 7; i++) begin
			e[i] = exp_q16(mx - s[i]);
			sum += e[i];
		end
		for (int i = 0; i < 7; i++)
			p[i] = (e[i] * 65536 + sum / 2) / sum;
		r.prob_0 = p[0][16:0];
		r.prob_1 = p[1][16:0];
		r.prob_2 = p[2][16:0];
		r.prob_3 = p[3][16:0];
		r.prob_4 = p[4][16:0];
		r.prob_5 = p[5][16:0];
		r.prob_6 = p[6][16:0];
		r.top_class = 3'(top);
		r.confidence_pct = 15'((e[top] * 25600 + sum / 2) / sum);
		return r;
	endfunction

	function automatic sma_pkg::scores_t vec_from(int a[7]);
		sma_pkg::scores_t v;
		v.score_0 = 8'(a[0]);
		v.score_1 = 8'(a[1]);
		v.score_2 = 8'(a[2]);
		v.score_3 = 8'(a[3]);
		v.score_4 = 8'(a[4]);
		v.score_5 = 8'(a[5]);
		v.score_6 = 8'(a[6]);
		return v;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// stimulus
	initial begin
		int a[7];
		int base;
		pending_vectors.push_back(vec_from('{0, 0, 0, 0, 0, 0, 0}));
		pending_vectors.push_back(vec_from('{-128, -128, -128, -128, -128, -128, -128}));
		pending_vectors.push_back(vec_from('{127, 127, 127, 127, 127, 127, 127}));
		pending_vectors.push_back(vec_from('{127, -128, -128, -128, -128, -128, -128}));
		pending_vectors.push_back(vec_from('{-128, -128, -128, -128, -128, -128, 127}));
		pending_vectors.push_back(vec_from('{-128, 127, -128, 127, -128, -128, -128}));
		pending_vectors.push_back(vec_from('{-1, 0, 1, 2, 3, 4, 5}));
		pending_vectors.push_back(vec_from('{5, 4, 3, 2, 1, 0, -1}));
		pending_vectors.push_back(vec_from('{0, -11, -12, -17, -18, -10, -1}));
		pending_vectors.push_back(vec_from('{-3, 10, 10, 9, -100, 127, 126}));
		pending_vectors.push_back(vec_from('{85, -86, 42, -43, 21, -22, 0}));
		pending_vectors.push_back(vec_from('{-86, 85, -43, 42, -22, 21, 1}));
		for (int c = 0; c < 7; c++) begin
			for (int i = 0; i < 7; i++)
				a[i] = 20 - i;
			a[c] = 30;
			pending_vectors.push_back(vec_from(a));
		end
		for (int n = 0; n < 600; n++) begin
			case ($urandom_range(0, 3))
				0: for (int i = 0; i < 7; i++)
					a[i] = $urandom_range(0, 255) - 128;
				1: begin
					base = $urandom_range(0, 255) - 128;
					for (int i = 0; i < 7; i++) begin
						a[i] = base - int'($urandom_range(0, 20));
						if (a[i] < -128)
							a[i] = -128;
					end
				end
				2: begin
					base = $urandom_range(0, 255) - 128;
					for (int i = 0; i < 7; i++)
						a[i] = ($urandom_range(0, 2) == 0) ? base :
							int'($urandom_range(0, 255)) - 128;
				end
				default: for (int i = 0; i < 7; i++)
					a[i] = ($urandom_range(0, 1) == 0) ? 127 : -128 + int'($urandom_range(0, 3));
			endcase
			pending_vectors.push_back(vec_from(a));
		end
		stim_done = 1;
	end

	// driver: bursts with random gaps
	int burst_left;
	int gap_left;
	initial begin
		start = 0;
		scores = '0;
		burst_left = 0;
		gap_left = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(softmax_of(scores));
				pending_vectors.pop_front();
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 0;
			end else if (pending_vectors.size() > 0) begin
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else
					burst_left <= burst_left - 1;
				if (pending_vectors.size() > 0) begin
					start <= 1;
					scores <= pending_vectors[0];
				end else
					start <= 0;
			end else
				start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		sma_pkg::result_t x;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				x = expected_results.pop_front();
				if (result.prob_0 !== x.prob_0) begin
					$error("prob_0 exp %0d got %0d", x.prob_0, result.prob_0); errors++;
				end
				if (result.prob_1 !== x.prob_1) begin
					$error("prob_1 exp %0d got %0d", x.prob_1, result.prob_1); errors++;
				end
				if (result.prob_2 !== x.prob_2) begin
					$error("prob_2 exp %0d got %0d", x.prob_2, result.prob_2); errors++;
				end
				if (result.prob_3 !== x.prob_3) begin
					$error("prob_3 exp %0d got %0d", x.prob_3, result.prob_3); errors++;
				end
				if (result.prob_4 !== x.prob_4) begin
					$error("prob_4 exp %0d got %0d", x.prob_4, result.prob_4); errors++;
				end
				if (result.prob_5 !== x.prob_5) begin
					$error("prob_5 exp %0d got %0d", x.prob_5, result.prob_5); errors++;
				end
				if (result.prob_6 !== x.prob_6) begin
					$error("prob_6 exp %0d got %0d", x.prob_6, result.prob_6); errors++;
				end
				if (result.top_class !== x.top_class) begin
					$error("top_class exp %0d got %0d", x.top_class, result.top_class);
					errors++;
				end
				if (result.confidence_pct !== x.confidence_pct) begin
					$error("confidence_pct exp %0d got %0d", x.confidence_pct,
						result.confidence_pct);
					errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		errors = 0;
		wait (stim_done);
		wait (arst_n && pending_vectors.size() == 0);
		@(negedge clk);
		@(negedge clk);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("int8_softmax_argmax regression: pass");
		else
			$display("int8_softmax_argmax regression: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("int8_softmax_argmax regression: fail");
		$finish;
	end
endmodule

[int8_softmax_argmax.f]
sv/sma_pkg.sv
sv/sma_div.sv
sv/sma_front.sv
sv/int8_softmax_argmax.sv
verif/tb.sv
